>>> design/mcodp_pkg.sv
// mcodp_pkg: word types and fixed constants for the matrix chain order block
// depends on nothing; imported by matrix_chain_order_dp
package mcodp_pkg;

  localparam int DIM_FIELD_W = 16;
  localparam int COST_W      = 64;
  localparam int SPLIT_W     = 5;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  // input word: one dimension, flag on the last one of a chain
  typedef struct packed {
    logic [DIM_FIELD_W-1:0] dim_value;
    logic                   last;
  } mcodp_in_t;

  // result word: one per chain
  typedef struct packed {
    logic [COST_W-1:0]  min_cost;
    logic [SPLIT_W-1:0] top_split;
    logic               saturated;
    logic               too_long;
    logic               too_short;
  } mcodp_out_t;

endpackage

>>> design/matrix_chain_order_dp.sv
// matrix_chain_order_dp: minimum multiplication count and top split of a matrix chain
// depends on mcodp_pkg (word types, cost width, saturation value)
//
//   channel  dir  handshake                 payload
//   in_      in   in_valid / in_ready       mcodp_in_t: dim_value, last
//   out_     out  out_valid / out_ready     mcodp_out_t: min_cost, top_split, flags
//
// a word without last is stored; the word with last starts the table fill if the chain has
// more than one matrix. fill: each span (i,j) passes the setup states, then issues the splits
// k from i to j-1 in turn to the shared multiply/add unit, then drains the unit's pipeline.
// the single read port of the dimension store fetches p[i-1] and p[j] during setup.
// rst_n is synchronous; tables are not cleared, every entry read is written first.
// in_ready is low during the fill; a waiting result word does not block new words.
module matrix_chain_order_dp #(
  parameter int MAX_DIMS = 32,
  parameter int DIM_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mcodp_pkg::mcodp_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mcodp_pkg::mcodp_out_t  out_data
);
  import mcodp_pkg::*;

  localparam int IDX_W  = $clog2(MAX_DIMS);
  localparam int CNT_W  = $clog2(MAX_DIMS + 1);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int M1_W   = 2 * DIM_BITS;
  localparam int PROD_W = 3 * DIM_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETUPA = 3'd1;
  localparam logic [2:0] S_SETUPB = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[COST_W] ? COST_MAX : s[COST_W-1:0];
    end
  endfunction

  // memories
  logic [DIM_BITS-1:0] dim_mem [MAX_DIMS];
  logic [COST_W-1:0]   cost_mem [2**ADDR_W];

  // control
  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] dim_count_r;
  logic             ovf_r;
  logic             too_long_r, too_short_r;
  logic [IDX_W-1:0] last_idx_r;
  logic [IDX_W-1:0] len_r, i_r, j_r, k_r;
  logic             v1_r, v2_r, v3_r;
  logic             sat_seen_r;
  logic             out_valid_r;

  // datapath
  logic [DIM_BITS-1:0] dim_rd_r;
  logic [COST_W-1:0]   ca_rd_r, cb_rd_r;
  logic [DIM_BITS-1:0] pim1_r, pj_r;
  logic                z1a_r, z1b_r;
  logic [IDX_W-1:0]    k1_r, k2_r, k3_r;
  logic [M1_W-1:0]     m1_r;
  logic [COST_W-1:0]   sum2_r, sum3_r;
  logic [PROD_W-1:0]   prod_r;
  logic [COST_W-1:0]   best_r;
  logic [IDX_W-1:0]    best_k_r;
  mcodp_out_t          out_data_r;

  logic                   in_acc;
  logic [DIM_BITS+DIM_FIELD_W-1:0] din_ext;
  logic [DIM_BITS-1:0]    din;
  logic [IDX_W-1:0]       kp1, j_m1, dim_raddr;
  logic                   dim_re;
  logic                   pipe_empty;
  logic                   span_done;
  logic                   cost_we;
  logic [COST_W-1:0]      ca_eff, cb_eff, q3;
  logic [IDX_W+SPLIT_W-1:0] split_ext;
  logic                   out_load;

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // the dimension field is zero-extended to DIM_BITS, or cut to its low DIM_BITS bits if narrower
  assign din_ext    = {{DIM_BITS{1'b0}}, in_data.dim_value};
  assign din        = din_ext[DIM_BITS-1:0];

  assign kp1        = k_r + IDX_W'(1);
  assign j_m1       = j_r - IDX_W'(1);
  assign pipe_empty = !v1_r && !v2_r && !v3_r;
  assign span_done  = (state_r == S_DRAIN) && pipe_empty;
  assign cost_we    = span_done;
  assign out_load   = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  // one read port on the dimension store: p[i-1], then p[j], then p[k] per cycle
  always_comb begin
    dim_raddr = k_r;
    dim_re    = 1'b0;
    case (state_r)
      S_SETUPA: begin
        dim_raddr = i_r - IDX_W'(1);
        dim_re    = 1'b1;
      end
      S_SETUPB: begin
        dim_raddr = j_r;
        dim_re    = 1'b1;
      end
      S_RUN: begin
        dim_raddr = k_r;
        dim_re    = 1'b1;
      end
      default: begin
        dim_raddr = k_r;
        dim_re    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && (dim_count_r < CNT_W'(MAX_DIMS))) begin
      dim_mem[dim_count_r[IDX_W-1:0]] <= din;
    end
    if (dim_re) begin
      dim_rd_r <= dim_mem[dim_raddr];
    end
  end

  // cost table: m[i][k] and m[k+1][j] read each cycle, finished span written once
  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[{i_r, j_r}] <= best_r;
    end
    ca_rd_r <= cost_mem[{i_r, k_r}];
    cb_rd_r <= cost_mem[{kp1, j_r}];
  end

  // shared unit, stage 1: diagonal terms are zero, first add and first multiply
  assign ca_eff = z1a_r ? '0 : ca_rd_r;
  assign cb_eff = z1b_r ? '0 : cb_rd_r;
  // stage 3: final add against the product, compare with the running best
  assign q3     = sat_add(sum3_r, COST_W'(prod_r));

  always_ff @(posedge clk) begin
    // p[i-1] arrives in the setup b cycle, p[j] in the first issue cycle
    if (state_r == S_SETUPB) begin
      pim1_r <= dim_rd_r;
    end
    if ((state_r == S_RUN) && (k_r == i_r)) begin
      pj_r <= dim_rd_r;
    end
    z1a_r  <= (k_r == i_r);
    z1b_r  <= (kp1 == j_r);
    k1_r   <= k_r;
    m1_r   <= M1_W'(pim1_r * dim_rd_r);
    sum2_r <= sat_add(ca_eff, cb_eff);
    k2_r   <= k1_r;
    prod_r <= PROD_W'(m1_r * pj_r);
    sum3_r <= sum2_r;
    k3_r   <= k2_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.last) begin
          state_nxt = (dim_count_r <= CNT_W'(1)) ? S_FINISH : S_SETUPA;
          // two stored dimensions means one matrix: nothing to fill
          if (dim_count_r == CNT_W'(1)) state_nxt = S_FINISH;
        end
      end
      S_SETUPA: state_nxt = S_SETUPB;
      S_SETUPB: state_nxt = S_RUN;
      S_RUN: begin
        if (k_r == j_m1) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = ((i_r == IDX_W'(1)) && (j_r == last_idx_r)) ? S_FINISH : S_SETUPA;
        end
      end
      S_FINISH: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dim_count_r <= '0;
      ovf_r       <= 1'b0;
      too_long_r  <= 1'b0;
      too_short_r <= 1'b0;
      last_idx_r  <= '0;
      len_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      sat_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == S_RUN);
      v2_r    <= v1_r;
      v3_r    <= v2_r;

      if (in_acc) begin
        if (in_data.last) begin
          // chain closes: capture flags and the index of the last dimension
          dim_count_r <= '0;
          ovf_r       <= 1'b0;
          too_long_r  <= ovf_r || (dim_count_r == CNT_W'(MAX_DIMS));
          too_short_r <= (dim_count_r == '0);
          sat_seen_r  <= 1'b0;
          last_idx_r  <= (dim_count_r < CNT_W'(MAX_DIMS)) ? dim_count_r[IDX_W-1:0]
                                                          : IDX_W'(MAX_DIMS - 1);
          len_r       <= IDX_W'(2);
          i_r         <= IDX_W'(1);
          j_r         <= IDX_W'(2);
        end else if (dim_count_r < CNT_W'(MAX_DIMS)) begin
          dim_count_r <= dim_count_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end

      if (state_r == S_SETUPA) begin
        k_r <= i_r;
      end
      if (state_r == S_RUN) begin
        k_r <= kp1;
      end
      if (v3_r && (q3 == COST_MAX)) begin
        sat_seen_r <= 1'b1;
      end

      // span written this cycle: step to the next span of this length or the next length
      if (span_done && (j_r != last_idx_r)) begin
        i_r <= i_r + IDX_W'(1);
        j_r <= j_r + IDX_W'(1);
      end else if (span_done && (i_r != IDX_W'(1))) begin
        len_r <= len_r + IDX_W'(1);
        i_r   <= IDX_W'(1);
        j_r   <= len_r + IDX_W'(1);
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // running best of the current span, also the result of the final span
  assign split_ext = {{SPLIT_W{1'b0}}, best_k_r};

  always_ff @(posedge clk) begin
    if (state_r == S_SETUPA) begin
      best_r   <= COST_MAX;
      best_k_r <= i_r;
    end else if (in_acc && in_data.last) begin
      best_r   <= '0;
      best_k_r <= '0;
    end else if (v3_r && (q3 < best_r)) begin
      best_r   <= q3;
      best_k_r <= k3_r;
    end
    if (out_load) begin
      out_data_r.min_cost  <= best_r;
      out_data_r.top_split <= split_ext[SPLIT_W-1:0];
      out_data_r.saturated <= sat_seen_r;
      out_data_r.too_long  <= too_long_r;
      out_data_r.too_short <= too_short_r;
    end
  end

  // issue index stays inside the span
  a_k_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> ((k_r >= i_r) && (k_r < j_r)))
    else $error("split index left its span");

  // span bounds agree with the current length and the chain end
  a_span_shape: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SETUPA) || (state_r == S_SETUPB) || (state_r == S_RUN) ||
     (state_r == S_DRAIN)) |-> (((j_r - i_r) == (len_r - IDX_W'(1))) && (j_r <= last_idx_r)))
    else $error("span bounds inconsistent");

  // the split stored for a span is one of its own candidates
  a_best_k: assert property (@(posedge clk) disable iff (!rst_n)
    span_done |-> ((best_k_r >= i_r) && (best_k_r < j_r)))
    else $error("best split outside span");

  // no new word while the shared unit still holds work
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> pipe_empty)
    else $error("word accepted with unit busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dim_count_r <= CNT_W'(MAX_DIMS))
    else $error("dimension count past capacity");

endmodule
